// File: sv/dqs_pkg.sv
// Shared types, constants and index helpers for the bounded deque with search.
package dqs_pkg;

  localparam int DEPTH       = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] CMD_PUSH_TAIL = 3'd0;
  localparam logic [2:0] CMD_PUSH_HEAD = 3'd1;
  localparam logic [2:0] CMD_POP_TAIL  = 3'd2;
  localparam logic [2:0] CMD_POP_HEAD  = 3'd3;
  localparam logic [2:0] CMD_READ      = 3'd4;
  localparam logic [2:0] CMD_SEARCH    = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [2:0] {
    OP_PUSH_TAIL,
    OP_PUSH_HEAD,
    OP_POP_TAIL,
    OP_POP_HEAD,
    OP_READ,
    OP_SEARCH,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [2:0]   cmd;
    logic signed [31:0] value;
    logic [4:0]   position;
  } req_t;

  typedef struct packed {
    logic [1:0]   status;
    logic         found;
    logic signed [31:0] data;
    logic [4:0]   occupancy;
  } rsp_t;

  typedef struct packed {
    op_t        op;
    word_t      word;
    logic [4:0] position;
  } desc_t;

  function automatic idx_t slot(idx_t base, idx_t off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W + 1)'(DEPTH)) begin
      sum = sum - (IDX_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// File: sv/dqs_front.sv
// Front end: request register and command classification.
module dqs_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  dqs_pkg::req_t   req,
  output logic            desc_valid,
  input  logic            desc_ready,
  output dqs_pkg::desc_t  desc
);
  import dqs_pkg::*;

  desc_t decoded;

  always_comb begin
    decoded.word     = word_t'($unsigned(req.value));
    decoded.position = req.position;
    case (req.cmd)
      CMD_PUSH_TAIL: decoded.op = OP_PUSH_TAIL;
      CMD_PUSH_HEAD: decoded.op = OP_PUSH_HEAD;
      CMD_POP_TAIL:  decoded.op = OP_POP_TAIL;
      CMD_POP_HEAD:  decoded.op = OP_POP_HEAD;
      CMD_READ:      decoded.op = OP_READ;
      CMD_SEARCH:    decoded.op = OP_SEARCH;
      default:       decoded.op = OP_NOP;
    endcase
  end

  assign req_stall = desc_valid && !desc_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      desc_valid <= 1'b1;
    end else if (desc_ready) begin
      desc_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      desc <= decoded;
    end
  end

endmodule

// File: sv/dqs_queue.sv
// Short descriptor queue between front end and back end.
module dqs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  dqs_pkg::desc_t  push_desc,
  output logic            pop_valid,
  input  logic            pop_take,
  output dqs_pkg::desc_t  pop_desc
);
  import dqs_pkg::*;

  desc_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   fill;
  logic                do_push;
  logic                do_pop;

  assign push_ready = fill != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_desc   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_take && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_desc;
    end
  end

endmodule

// File: sv/dqs_back.sv
// Back end: circular entry store, command execution and response register.
module dqs_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            desc_valid,
  output logic            desc_take,
  input  dqs_pkg::desc_t  desc,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output dqs_pkg::rsp_t   rsp
);
  import dqs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t state, state_next;
  idx_t   head, head_next;
  cnt_t   count, count_next;
  idx_t   k, k_next;
  word_t  key, key_next;

  word_t  entries [DEPTH];
  word_t  rd_data;
  idx_t   raddr;
  idx_t   waddr;
  logic   we;

  logic   out_free;
  logic   res_we;
  rsp_t   res;

  function automatic word_t wdata_of(desc_t d);
    return d.word;
  endfunction

  assign out_free  = !rsp_valid || !rsp_stall;
  assign desc_take = (state == S_IDLE) && desc_valid && out_free;

  always_comb begin
    state_next = state;
    head_next  = head;
    count_next = count;
    k_next     = k;
    key_next   = key;
    we         = 1'b0;
    waddr      = head;
    raddr      = head;
    res_we     = 1'b0;
    res.status = ST_OK;
    res.found  = 1'b0;
    res.data   = '0;
    case (state)
      S_IDLE: begin
        if (desc_take) begin
          case (desc.op)
            OP_PUSH_TAIL: begin
              res_we = 1'b1;
              if (count == CNT_W'(DEPTH)) begin
                res.status = ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = slot(head, IDX_W'(count));
                count_next = count + CNT_W'(1);
              end
            end
            OP_PUSH_HEAD: begin
              res_we = 1'b1;
              if (count == CNT_W'(DEPTH)) begin
                res.status = ST_FULL;
              end else begin
                we         = 1'b1;
                head_next  = slot(head, IDX_W'(DEPTH - 1));
                waddr      = head_next;
                count_next = count + CNT_W'(1);
              end
            end
            OP_POP_TAIL: begin
              res_we = 1'b1;
              if (count == '0) begin
                res.status = ST_EMPTY;
              end else begin
                count_next = count - CNT_W'(1);
              end
            end
            OP_POP_HEAD: begin
              res_we = 1'b1;
              if (count == '0) begin
                res.status = ST_EMPTY;
              end else begin
                head_next  = slot(head, IDX_W'(1));
                count_next = count - CNT_W'(1);
              end
            end
            OP_READ: begin
              if (desc.position == '0 || 32'(desc.position) > 32'(count)) begin
                res_we     = 1'b1;
                res.status = ST_BADPOS;
              end else begin
                raddr      = slot(head, IDX_W'(desc.position - 5'd1));
                state_next = S_READ;
              end
            end
            OP_SEARCH: begin
              if (count == '0) begin
                res_we = 1'b1;
              end else begin
                raddr      = head;
                k_next     = '0;
                key_next   = desc.word;
                state_next = S_SCAN;
              end
            end
            default: begin
              res_we = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        res_we     = 1'b1;
        res.found  = 1'b1;
        res.data   = 32'(rd_data);
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (rd_data == key) begin
          res_we     = 1'b1;
          res.found  = 1'b1;
          res.data   = 32'(rd_data);
          state_next = S_IDLE;
        end else if (CNT_W'(k) + CNT_W'(1) == count) begin
          res_we     = 1'b1;
          state_next = S_IDLE;
        end else begin
          k_next = k + IDX_W'(1);
          raddr  = slot(head, k_next);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    res.occupancy = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      entries[waddr] <= wdata_of(desc);
    end
    rd_data <= entries[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (res_we) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k   <= k_next;
    key <= key_next;
    if (res_we) begin
      rsp <= res;
    end
  end

endmodule

// File: sv/bounded_deque_with_search_core.sv
// Bounded double-ended queue of words with positional read and search by value.
//
// Requests pass a front register and a two-entry queue before the back end
// runs them against a circular store of DEPTH words held in a memory with one
// registered read port. Push, pop and rejected commands are answered from the
// idle state; a read waits in S_READ for the registered memory read; a search
// compares entries one at a time from the head through the single read port
// in S_SCAN, stopping at the first match or after the last live entry. Each
// request gives exactly one response. The store needs no clearing after
// reset: only live entries are ever read.
module bounded_deque_with_search_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  dqs_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output dqs_pkg::rsp_t  rsp
);
  import dqs_pkg::*;

  logic  front_valid;
  logic  front_ready;
  desc_t front_desc;
  logic  q_valid;
  logic  q_take;
  desc_t q_desc;

  dqs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .desc_valid (front_valid),
    .desc_ready (front_ready),
    .desc       (front_desc)
  );

  dqs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_desc  (front_desc),
    .pop_valid  (q_valid),
    .pop_take   (q_take),
    .pop_desc   (q_desc)
  );

  dqs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (q_valid),
    .desc_take  (q_take),
    .desc       (q_desc),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

  a_stall_needs_held_item: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> front_valid && !front_ready)
    else $error("request stalled without a held item blocked by the queue");

  a_found_is_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found |-> rsp.status == ST_OK)
    else $error("found response with error status");

  a_miss_has_zero_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> rsp.data == '0)
    else $error("response without hit carries data");

  a_take_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_valid)
    else $error("back end took from an empty queue");

endmodule

// File: tb/sv/bounded_deque_with_search_core_tb.sv
// Self-checking testbench for the bounded deque with search, driven and checked per transfer.
module bounded_deque_with_search_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dqs_pkg::*;

  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_ITEMS    = 380;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_stall;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp;

  word_t shadow_store [DEPTH];
  idx_t  shadow_head = '0;
  cnt_t  shadow_count = '0;
  rsp_t  rsp_due [$];

  int mismatches = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  bounded_deque_with_search_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial forever #5 clk = ~clk;

  function automatic rsp_t apply_to_shadow(req_t r);
    rsp_t  o;
    word_t w;
    int    k;
    o = '0;
    w = word_t'(r.value);
    case (r.cmd)
      CMD_PUSH_TAIL: begin
        if (shadow_count >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          shadow_store[(int'(shadow_head) + int'(shadow_count)) % DEPTH] = w;
          shadow_count = shadow_count + 1'b1;
        end
      end
      CMD_PUSH_HEAD: begin
        if (shadow_count >= DEPTH) begin
          o.status = ST_FULL;
        end else begin
          shadow_head = idx_t'((int'(shadow_head) + DEPTH - 1) % DEPTH);
          shadow_store[shadow_head] = w;
          shadow_count = shadow_count + 1'b1;
        end
      end
      CMD_POP_TAIL: begin
        if (shadow_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          shadow_count = shadow_count - 1'b1;
        end
      end
      CMD_POP_HEAD: begin
        if (shadow_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          shadow_head = idx_t'((int'(shadow_head) + 1) % DEPTH);
          shadow_count = shadow_count - 1'b1;
        end
      end
      CMD_READ: begin
        if (r.position == 0 || r.position > shadow_count) begin
          o.status = ST_BADPOS;
        end else begin
          o.found = 1'b1;
          o.data = shadow_store[(int'(shadow_head) + int'(r.position) - 1) % DEPTH];
        end
      end
      CMD_SEARCH: begin
        for (k = 0; k < int'(shadow_count); k++) begin
          if (!o.found && shadow_store[(int'(shadow_head) + k) % DEPTH] == w) begin
            o.found = 1'b1;
            o.data = w;
          end
        end
      end
      default: begin
      end
    endcase
    o.occupancy = 5'(shadow_count);
    return o;
  endfunction

  function automatic logic [31:0] pick_word();
    int roll;
    roll = $urandom_range(99);
    if (roll < 20) begin
      return 32'($urandom_range(0, 7));
    end else if (roll < 30) begin
      case ($urandom_range(3))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  function automatic req_t pick_cmd(int push_pct);
    req_t r;
    int   roll;
    r.cmd = CMD_READ;
    r.value = pick_word();
    r.position = 5'($urandom_range(0, 31));
    roll = $urandom_range(99);
    if (roll < 3) begin
      r.cmd = ($urandom_range(1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
    end else if (roll < 58) begin
      if ($urandom_range(99) < push_pct) begin
        r.cmd = ($urandom_range(1) != 0) ? CMD_PUSH_TAIL : CMD_PUSH_HEAD;
      end else begin
        r.cmd = ($urandom_range(1) != 0) ? CMD_POP_TAIL : CMD_POP_HEAD;
      end
    end else if (roll < 80) begin
      if (shadow_count != 0 && $urandom_range(99) < 80) begin
        r.position = 5'($urandom_range(1, int'(shadow_count)));
      end
    end else begin
      r.cmd = CMD_SEARCH;
      if (shadow_count != 0 && $urandom_range(99) < 70) begin
        r.value = shadow_store[(int'(shadow_head) +
                               $urandom_range(0, int'(shadow_count) - 1)) % DEPTH];
      end
    end
    return r;
  endfunction

  task automatic send_item(input logic [2:0] c, input logic [31:0] v, input logic [4:0] p);
    req_t r;
    r.cmd = c;
    r.value = v;
    r.position = p;
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    rsp_due.push_back(apply_to_shadow(r));
    if ($urandom_range(99) < send_gap_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_random(input int push_pct);
    req_t r;
    r = pick_cmd(push_pct);
    send_item(r.cmd, r.value, r.position);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  task automatic test_directed();
    send_item(CMD_POP_TAIL, 32'd0, 5'd0);
    send_item(CMD_POP_HEAD, 32'hffff_ffff, 5'd31);
    send_item(CMD_READ, 32'd0, 5'd0);
    send_item(CMD_READ, 32'd0, 5'd1);
    send_item(CMD_SEARCH, 32'd0, 5'd0);
    send_item(CMD_SPARE_A, 32'hffff_ffff, 5'd31);
    send_item(CMD_SPARE_B, 32'h5555_aaaa, 5'd16);
    send_item(CMD_PUSH_TAIL, 32'h7fff_ffff, 5'd0);
    send_item(CMD_PUSH_HEAD, 32'h8000_0000, 5'd0);
    send_item(CMD_PUSH_TAIL, 32'hffff_ffff, 5'd0);
    send_item(CMD_PUSH_HEAD, 32'h0000_0000, 5'd0);
    send_item(CMD_READ, 32'd0, 5'd1);
    send_item(CMD_READ, 32'd0, 5'd4);
    send_item(CMD_READ, 32'd0, 5'd0);
    send_item(CMD_READ, 32'd0, 5'd5);
    send_item(CMD_READ, 32'd0, 5'd31);
    send_item(CMD_SEARCH, 32'h8000_0000, 5'd0);
    send_item(CMD_SEARCH, 32'd12345, 5'd0);
    send_item(CMD_PUSH_TAIL, 32'h7fff_ffff, 5'd0);
    send_item(CMD_SEARCH, 32'h7fff_ffff, 5'd0);
    send_item(CMD_POP_TAIL, 32'd0, 5'd0);
    send_item(CMD_POP_HEAD, 32'd0, 5'd0);
    send_item(CMD_POP_HEAD, 32'd0, 5'd0);
    send_item(CMD_POP_HEAD, 32'd0, 5'd0);
    send_item(CMD_POP_TAIL, 32'd0, 5'd0);
  endtask

  task automatic test_fill_and_wrap();
    int k;
    for (k = 0; k < DEPTH; k++) send_item(CMD_PUSH_TAIL, pick_word(), 5'd0);
    send_item(CMD_PUSH_TAIL, pick_word(), 5'd0);
    send_item(CMD_PUSH_HEAD, pick_word(), 5'd0);
    send_item(CMD_READ, 32'd0, 5'(DEPTH));
    send_item(CMD_READ, 32'd0, 5'(DEPTH + 1));
    send_item(CMD_SEARCH,
              shadow_store[(int'(shadow_head) + int'(shadow_count) - 1) % DEPTH], 5'd0);
    for (k = 0; k < 5; k++) send_item(CMD_POP_HEAD, 32'd0, 5'd0);
    for (k = 0; k < 5; k++) send_item(CMD_PUSH_TAIL, pick_word(), 5'd0);
    send_item(CMD_READ, 32'd0, 5'd1);
    send_item(CMD_READ, 32'd0, 5'(DEPTH));
    send_item(CMD_SEARCH, pick_word(), 5'd0);
    for (k = 0; k <= DEPTH; k++) send_item(CMD_POP_TAIL, 32'd0, 5'd0);
    for (k = 0; k <= DEPTH; k++) send_item(CMD_PUSH_HEAD, pick_word(), 5'd0);
    for (k = 1; k <= DEPTH; k++) send_item(CMD_READ, 32'd0, 5'(k));
    for (k = 0; k <= DEPTH; k++) send_item(CMD_POP_HEAD, 32'd0, 5'd0);
  endtask

  task automatic test_random_traffic(input int gap_pct, input int stall_v, input int n);
    int k;
    int push_pct;
    send_gap_pct = gap_pct;
    stall_pct = stall_v;
    push_pct = 50;
    for (k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 25;
          1: push_pct = 50;
          default: push_pct = 80;
        endcase
      end
      send_random(push_pct);
    end
  endtask

  task automatic test_backpressure();
    int k;
    wait_drained();
    send_gap_pct = 0;
    stall_pct = 0;
    hold_req = 250;
    for (k = 0; k < 60; k++) send_random(60);
  endtask

  // receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (rsp_due.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %p", $time, rsp);
        mismatches++;
      end else begin
        want = rsp_due.pop_front();
        check_field("status", want.status, rsp.status);
        check_field("found", want.found, rsp.found);
        check_field("data", want.data, rsp.data);
        check_field("occupancy", want.occupancy, rsp.occupancy);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fill_and_wrap();
    test_random_traffic(0, 0, PHASE_ITEMS);
    test_random_traffic(47, 0, PHASE_ITEMS);
    test_random_traffic(0, 47, PHASE_ITEMS);
    test_random_traffic(11, 11, PHASE_ITEMS);
    test_backpressure();
    test_random_traffic(11, 11, 40);
    req_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/dqs_pkg.sv
sv/dqs_front.sv
sv/dqs_queue.sv
sv/dqs_back.sv
sv/bounded_deque_with_search_core.sv
tb/sv/bounded_deque_with_search_core_tb.sv
